[design/crrt_pkg.sv]
// Shared types and constants for the chained range remap table.
`default_nettype none

package crrt_pkg;

  localparam int NUM_STAGES_DFLT        = 7;
  localparam int ENTRIES_PER_STAGE_DFLT = 64;
  localparam int WORD_W                 = 32;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_ZERO = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    OP_INSERT    = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_SCAN,
    S_TR_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] dst;
    logic [WORD_W-1:0] len;
  } entry_t;

  // Sequencer controls for the match unit
  typedef struct packed {
    logic clr;
    logic load;
    logic proc;
    logic apply;
    logic ins_mode;
  } mctl_t;

endpackage

`default_nettype wire

[design/chained_range_remap_table_top.sv]
// Top level of the chained range remap table: sequencer, fill counts, output register.
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid/in_ready, in_op, in_stage, in_source_base, | in
//          | in_dest_base, in_span, in_query                     |
//  result  | out_valid/out_ready, out_status, out_mapped,        | out
//          | out_lowest                                          |
//
// The entry memory has one read port, read one entry per cycle. An insert scans its stage
// for a duplicate start, then writes unless it found one or the stage is full; a rejected
// zero span or bad stage skips the scan. A translate scans every stage in turn, stage 0
// first. The next item is accepted once the result word is loaded into the output register.
// Reset is synchronous active low; per-stage fill counts stand for the used bits,
// so there is no memory clearing pass. in_ready is high only in idle; a finished
// word waits in the output register while the next item is accepted.
`default_nettype none

module chained_range_remap_table_top #(
  parameter int NUM_STAGES        = crrt_pkg::NUM_STAGES_DFLT,
  parameter int ENTRIES_PER_STAGE = crrt_pkg::ENTRIES_PER_STAGE_DFLT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [2:0]  in_stage,
  input  wire logic [31:0] in_source_base,
  input  wire logic [31:0] in_dest_base,
  input  wire logic [31:0] in_span,
  input  wire logic [31:0] in_query,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_mapped,
  output logic [31:0]      out_lowest
);

  localparam int W     = crrt_pkg::WORD_W;
  localparam int DEPTH = NUM_STAGES * ENTRIES_PER_STAGE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int IW    = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
  localparam int FW    = $clog2(ENTRIES_PER_STAGE + 1);

  crrt_pkg::state_t  state_r, state_nxt;
  crrt_pkg::op_t     op_r, op_nxt;
  crrt_pkg::status_t status_r, status_nxt;
  logic [SW-1:0]     stg_r, stg_nxt;
  logic [FW-1:0]     iss_r, iss_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [W-1:0]      key_r, key_nxt;
  logic [W-1:0]      dst_r, dst_nxt;
  logic [W-1:0]      len_r, len_nxt;
  logic [W-1:0]      min_r, min_nxt;
  logic [FW-1:0]     fill_r   [NUM_STAGES];
  logic [FW-1:0]     fill_nxt [NUM_STAGES];
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [W-1:0]      out_mapped_r, out_mapped_nxt;
  logic [W-1:0]      out_lowest_r, out_lowest_nxt;

  crrt_pkg::mctl_t   ctl;
  crrt_pkg::entry_t  rd_entry;
  crrt_pkg::entry_t  wr_entry;
  logic [W-1:0]      value;
  logic              dup;

  logic [FW-1:0] fill_cur;
  logic          scanning;
  logic          issue;
  logic          scan_done;
  logic          last_stg;
  logic          stg_full;
  logic          accept;
  logic          bad_stage;
  logic          rd_en;
  logic          wr_en;
  logic          out_load;
  logic          stg_adv;
  logic [AW-1:0] stg_base;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  assign fill_cur  = fill_r[stg_r];
  assign scanning  = (state_r == crrt_pkg::S_INS_SCAN) || (state_r == crrt_pkg::S_TR_SCAN);
  assign issue     = scanning && (iss_r < fill_cur);
  assign scan_done = !issue && !rd_vld_r;
  assign last_stg  = (stg_r == SW'(NUM_STAGES - 1));
  assign stg_full  = (fill_cur == FW'(ENTRIES_PER_STAGE));
  assign accept    = in_valid && in_ready;
  assign bad_stage = ({29'd0, in_stage} >= 32'(NUM_STAGES));

  assign stg_base = AW'(AW'(stg_r) * AW'(ENTRIES_PER_STAGE));
  assign rd_addr  = AW'(stg_base + AW'(iss_r[IW-1:0]));
  assign wr_addr  = AW'(stg_base + AW'(fill_cur[IW-1:0]));
  assign wr_entry = '{src: key_r, dst: dst_r, len: len_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crrt_pkg::S_IDLE: begin
        if (in_valid) begin
          if (crrt_pkg::op_t'(in_op) == crrt_pkg::OP_TRANSLATE) begin
            state_nxt = crrt_pkg::S_TR_SCAN;
          end else if ((in_span == '0) || bad_stage) begin
            state_nxt = crrt_pkg::S_FINISH;
          end else begin
            state_nxt = crrt_pkg::S_INS_SCAN;
          end
        end
      end
      crrt_pkg::S_INS_SCAN: begin
        if (scan_done) begin
          state_nxt = crrt_pkg::S_FINISH;
        end
      end
      crrt_pkg::S_TR_SCAN: begin
        if (scan_done && last_stg) begin
          state_nxt = crrt_pkg::S_FINISH;
        end
      end
      crrt_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = crrt_pkg::S_IDLE;
        end
      end
      default: state_nxt = crrt_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready     = (state_r == crrt_pkg::S_IDLE);
    rd_en        = issue;
    wr_en        = (state_r == crrt_pkg::S_INS_SCAN) && scan_done && !dup && !stg_full;
    stg_adv      = (state_r == crrt_pkg::S_TR_SCAN) && scan_done && !last_stg;
    out_load     = (state_r == crrt_pkg::S_FINISH) && (!out_valid_r || out_ready);
    ctl.clr      = accept || stg_adv;
    ctl.load     = accept && (crrt_pkg::op_t'(in_op) == crrt_pkg::OP_TRANSLATE);
    ctl.proc     = rd_vld_r;
    ctl.apply    = (state_r == crrt_pkg::S_TR_SCAN) && scan_done;
    ctl.ins_mode = (state_r == crrt_pkg::S_INS_SCAN);
  end

  // Datapath registers
  always_comb begin
    op_nxt         = op_r;
    status_nxt     = status_r;
    stg_nxt        = stg_r;
    iss_nxt        = issue ? FW'(iss_r + 1'b1) : iss_r;
    rd_vld_nxt     = issue;
    key_nxt        = key_r;
    dst_nxt        = dst_r;
    len_nxt        = len_r;
    min_nxt        = min_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_mapped_nxt = out_mapped_r;
    out_lowest_nxt = out_lowest_r;

    if (accept) begin
      op_nxt  = crrt_pkg::op_t'(in_op);
      key_nxt = in_source_base;
      dst_nxt = in_dest_base;
      len_nxt = in_span;
      iss_nxt = '0;
      if (crrt_pkg::op_t'(in_op) == crrt_pkg::OP_TRANSLATE) begin
        stg_nxt    = '0;
        status_nxt = crrt_pkg::STAT_OK;
      end else begin
        // keep the stage pointer inside the table for a bad stage
        stg_nxt = bad_stage ? '0 : SW'(in_stage);
        if (in_span == '0) begin
          status_nxt = crrt_pkg::STAT_ZERO;
        end else if (bad_stage) begin
          status_nxt = crrt_pkg::STAT_FULL;
        end else begin
          status_nxt = crrt_pkg::STAT_OK;
        end
      end
    end

    if ((state_r == crrt_pkg::S_INS_SCAN) && scan_done) begin
      if (dup) begin
        status_nxt = crrt_pkg::STAT_DUP;
      end else if (stg_full) begin
        status_nxt = crrt_pkg::STAT_FULL;
      end else begin
        status_nxt = crrt_pkg::STAT_OK;
      end
    end

    if (wr_en) begin
      fill_nxt[stg_r] = FW'(fill_cur + 1'b1);
    end

    if (stg_adv) begin
      stg_nxt = SW'(stg_r + 1'b1);
      iss_nxt = '0;
    end

    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      if (op_r == crrt_pkg::OP_TRANSLATE) begin
        out_mapped_nxt = value;
        min_nxt        = (value < min_r) ? value : min_r;
        out_lowest_nxt = min_nxt;
      end else begin
        out_mapped_nxt = '0;
        out_lowest_nxt = min_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crrt_pkg::S_IDLE;
      stg_r       <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      min_r       <= '1;
      for (int s = 0; s < NUM_STAGES; s++) begin
        fill_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      stg_r       <= stg_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      min_r       <= min_nxt;
      fill_r      <= fill_nxt;
    end
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    key_r        <= key_nxt;
    dst_r        <= dst_nxt;
    len_r        <= len_nxt;
    out_status_r <= out_status_nxt;
    out_mapped_r <= out_mapped_nxt;
    out_lowest_r <= out_lowest_nxt;
  end

  crrt_ram #(
    .WIDTH ($bits(crrt_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  crrt_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .query    (in_query),
    .key      (key_r),
    .rd_entry (rd_entry),
    .value    (value),
    .dup      (dup)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_mapped = out_mapped_r;
  assign out_lowest = out_lowest_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cur <= FW'(ENTRIES_PER_STAGE))
    else $error("stage fill count beyond capacity");

  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r <= fill_cur)
    else $error("read pointer past stage fill");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == crrt_pkg::S_INS_SCAN || state_r == crrt_pkg::S_TR_SCAN))
    else $error("read data arrives outside a scan");

  a_min_falls: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (min_r <= $past(min_r)))
    else $error("running minimum went up");

  a_insert_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == crrt_pkg::STAT_OK || out_mapped_r == '0))
    else $error("rejected insert word carries a mapped value");

endmodule

`default_nettype wire

[design/crrt_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module crrt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 448,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/crrt_match.sv]
// Shared compare/select unit: best-entry tracking, remap and duplicate check.
`default_nettype none

module crrt_match (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire crrt_pkg::mctl_t              ctl,
  input  wire logic [crrt_pkg::WORD_W-1:0]  query,
  input  wire logic [crrt_pkg::WORD_W-1:0]  key,
  input  wire crrt_pkg::entry_t             rd_entry,
  output logic      [crrt_pkg::WORD_W-1:0]  value,
  output logic                              dup
);

  localparam int W = crrt_pkg::WORD_W;

  logic [W-1:0] val_r, val_nxt;
  logic [W-1:0] best_src_r, best_src_nxt;
  logic [W-1:0] best_dst_r, best_dst_nxt;
  logic         found_r, found_nxt;
  logic         dup_r, dup_nxt;
  logic         covers;
  logic         better;
  logic         take;

  always_comb begin
    // entry end >= value  <=>  src + len > value, taken on 33 bits
    covers = ({1'b0, rd_entry.src} + {1'b0, rd_entry.len}) > {1'b0, val_r};
    better = !found_r || (rd_entry.src < best_src_r);
    take   = ctl.proc && !ctl.ins_mode && covers && better;

    val_nxt = val_r;
    if (ctl.load) begin
      val_nxt = query;
    end else if (ctl.apply && found_r && (val_r >= best_src_r)) begin
      val_nxt = best_dst_r + (val_r - best_src_r);
    end

    best_src_nxt = take ? rd_entry.src : best_src_r;
    best_dst_nxt = take ? rd_entry.dst : best_dst_r;

    found_nxt = found_r;
    dup_nxt   = dup_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
      dup_nxt   = 1'b0;
    end else begin
      if (take) begin
        found_nxt = 1'b1;
      end
      if (ctl.proc && ctl.ins_mode && (rd_entry.src == key)) begin
        dup_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      dup_r   <= 1'b0;
    end else begin
      found_r <= found_nxt;
      dup_r   <= dup_nxt;
    end
    val_r      <= val_nxt;
    best_src_r <= best_src_nxt;
    best_dst_r <= best_dst_nxt;
  end

  assign value = val_r;
  assign dup   = dup_r;

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the chained range remap table top level.
`timescale 1ns / 100ps

module tb;

  localparam int STAGES      = crrt_pkg::NUM_STAGES_DFLT;
  localparam int SLOTS       = crrt_pkg::ENTRIES_PER_STAGE_DFLT;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_WAIT  = 40;
  localparam int RANDOM_OPS  = 1225;

  typedef struct {
    crrt_pkg::op_t op;
    logic [2:0]    stage;
    logic [31:0]   src;
    logic [31:0]   dst;
    logic [31:0]   span;
    logic [31:0]   query;
  } remap_req_t;

  typedef struct {
    crrt_pkg::status_t status;
    logic [31:0]       mapped;
    logic [31:0]       lowest;
  } remap_word_t;

  typedef struct {
    logic [2:0]  stage;
    logic [31:0] src;
    logic [31:0] span;
  } range_seen_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = 1'b0;
  logic [2:0]  in_stage = '0;
  logic [31:0] in_source_base = '0;
  logic [31:0] in_dest_base = '0;
  logic [31:0] in_span = '0;
  logic [31:0] in_query = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_mapped;
  logic [31:0] out_lowest;

  chained_range_remap_table_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_stage      (in_stage),
    .in_source_base(in_source_base),
    .in_dest_base  (in_dest_base),
    .in_span       (in_span),
    .in_query      (in_query),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_mapped    (out_mapped),
    .out_lowest    (out_lowest)
  );

  always #2 clk = ~clk;

  // Shadow copy of the range tables
  logic [31:0] tbl_src [STAGES][SLOTS];
  logic [31:0] tbl_dst [STAGES][SLOTS];
  logic [31:0] tbl_len [STAGES][SLOTS];
  int          tbl_fill [STAGES];
  logic [31:0] min_seen = 32'hFFFF_FFFF;

  remap_req_t  queued_ops [$];
  remap_word_t due_words [$];
  range_seen_t issued_ranges [$];
  remap_req_t  in_flight;
  int          errors = 0;
  int          gap_cnt = 0;
  int          hold_cnt = 0;
  int          cycles = 0;
  int          words_seen = 0;
  int          total_ops = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  initial begin
    for (int s = 0; s < STAGES; s++) tbl_fill[s] = 0;
  end

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic crrt_pkg::status_t add_range(remap_req_t r);
    int s;
    s = r.stage;
    if (r.span == 32'd0) return crrt_pkg::STAT_ZERO;
    if (s >= STAGES) return crrt_pkg::STAT_FULL;
    for (int i = 0; i < tbl_fill[s]; i++)
      if (tbl_src[s][i] == r.src) return crrt_pkg::STAT_DUP;
    if (tbl_fill[s] >= SLOTS) return crrt_pkg::STAT_FULL;
    tbl_src[s][tbl_fill[s]] = r.src;
    tbl_dst[s][tbl_fill[s]] = r.dst;
    tbl_len[s][tbl_fill[s]] = r.span;
    tbl_fill[s]++;
    return crrt_pkg::STAT_OK;
  endfunction

  // Pick the lowest start whose exact (unwrapped) end reaches the value
  function automatic logic [31:0] stage_map(int s, logic [31:0] v);
    bit          found;
    int          best;
    logic [32:0] top_end;
    found = 1'b0;
    best = 0;
    for (int i = 0; i < tbl_fill[s]; i++) begin
      top_end = {1'b0, tbl_src[s][i]} + {1'b0, tbl_len[s][i]} - 33'd1;
      if (top_end >= {1'b0, v} && (!found || tbl_src[s][i] < tbl_src[s][best])) begin
        best = i;
        found = 1'b1;
      end
    end
    if (found && v >= tbl_src[s][best]) return tbl_dst[s][best] + (v - tbl_src[s][best]);
    return v;
  endfunction

  function automatic void remap_predict(remap_req_t r);
    remap_word_t w;
    logic [31:0] v;
    w.status = crrt_pkg::STAT_OK;
    w.mapped = 32'd0;
    if (r.op == crrt_pkg::OP_INSERT) begin
      w.status = add_range(r);
    end else begin
      v = r.query;
      for (int s = 0; s < STAGES; s++) v = stage_map(s, v);
      if (v < min_seen) min_seen = v;
      w.mapped = v;
    end
    w.lowest = min_seen;
    due_words.insert(due_words.size(), w);
  endfunction

  task automatic push_insert(input int stg, input logic [31:0] src, input logic [31:0] dst,
                             input logic [31:0] span);
    remap_req_t r;
    range_seen_t g;
    r = '{crrt_pkg::OP_INSERT, 3'(stg), src, dst, span, $urandom};
    queued_ops.insert(queued_ops.size(), r);
    if (span != 32'd0) begin
      g = '{3'(stg), src, span};
      issued_ranges.insert(issued_ranges.size(), g);
    end
  endtask

  task automatic push_translate(input logic [31:0] q);
    remap_req_t r;
    r = '{crrt_pkg::OP_TRANSLATE, 3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, q};
    queued_ops.insert(queued_ops.size(), r);
  endtask

  // Driver: present one word at a time, hold it until accepted
  always @(posedge clk) begin
    bit next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) remap_predict(in_flight);
      if (!(in_valid && !in_ready)) begin
        next_valid = 1'b0;
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (queued_ops.size() > 0) begin
          in_flight = queued_ops.pop_front();
          in_op          <= in_flight.op;
          in_stage       <= in_flight.stage;
          in_source_base <= in_flight.src;
          in_dest_base   <= in_flight.dst;
          in_span        <= in_flight.span;
          in_query       <= in_flight.query;
          next_valid = 1'b1;
          if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
          gap_cnt = in_calm ? 0 : pick_pause();
        end
        in_valid <= next_valid;
      end
    end
  end

  // Monitor: check each accepted result word against the oldest prediction
  always @(posedge clk) begin
    remap_word_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (due_words.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing due: status %0d mapped %h lowest %h",
                   $time, out_status, out_mapped, out_lowest);
        end else begin
          w = due_words.pop_front();
          if (out_status !== w.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, w.status, out_status);
          end
          if (out_mapped !== w.mapped) begin
            errors++;
            $display("%0t: mapped mismatch: expected %h, actual %h",
                     $time, w.mapped, out_mapped);
          end
          if (out_lowest !== w.lowest) begin
            errors++;
            $display("%0t: lowest mismatch: expected %h, actual %h",
                     $time, w.lowest, out_lowest);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 7) == 0) hold_cnt = pick_pause();
      end
      if ($urandom_range(0, 299) == 0) out_calm = ~out_calm;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    range_seen_t g;
    logic [31:0] src;
    logic [31:0] span;
    logic [31:0] cap;
    int          stg;
    int          r;

    // Empty tables pass the value through
    push_translate(32'hFFFF_FFFF);
    // Zero span wins over bad stage and duplicate; bad stage reads as full
    push_insert(0, 32'd10, 32'd100, 32'd0);
    push_insert(7, 32'd1, 32'd2, 32'd5);
    push_insert(7, 32'd1, 32'd2, 32'd0);
    push_insert(0, 32'd10, 32'd100, 32'd5);
    push_insert(0, 32'd10, 32'd999, 32'd7);
    push_insert(0, 32'd10, 32'd999, 32'd0);
    // End past 2^32-1 covers the top; destination at 2^32-1
    push_insert(0, 32'hFFFF_FFF0, 32'd0, 32'hFFFF_FFFF);
    push_insert(0, 32'd0, 32'hFFFF_FFFF, 32'd1);
    // Overlapping ranges: smallest qualifying start wins
    push_insert(1, 32'd20, 32'd5, 32'd100);
    push_insert(1, 32'd50, 32'd1000, 32'd10);
    push_insert(6, 32'hFFFF_FFFF, 32'd7, 32'd1);
    push_insert(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_translate(32'hFFFF_FFFF);
    push_translate(32'hFFFF_FFF5);
    push_translate(32'd55);
    push_translate(32'd12);
    push_translate(32'd9);
    push_translate(32'd14);
    push_translate(32'd15);
    push_translate(32'h8000_0000);
    push_translate(32'd0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if ($urandom_range(0, 99) < 55) begin
        stg = ($urandom_range(0, 15) == 0) ? 7 : $urandom_range(0, STAGES - 1);
        r = $urandom_range(0, 7);
        if (r == 0 && issued_ranges.size() > 0) begin
          // reuse an earlier start in its own stage: duplicate
          g = issued_ranges[$urandom_range(0, issued_ranges.size() - 1)];
          stg = g.stage;
          src = g.src;
        end else if (r < 4) begin
          src = $urandom_range(0, 5000);
        end else begin
          src = $urandom;
        end
        r = $urandom_range(0, 15);
        if (r == 0) span = 32'd0;
        else if (r < 9) span = $urandom_range(1, 1000);
        else if (r < 13) span = $urandom_range(1, 32'h00FF_FFFF);
        else span = $urandom;
        push_insert(stg, src, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000) : $urandom,
                    span);
      end else begin
        if ($urandom_range(0, 2) == 0 || issued_ranges.size() == 0) begin
          push_translate($urandom);
        end else begin
          // land near an inserted range, just inside or just outside it
          g = issued_ranges[$urandom_range(0, issued_ranges.size() - 1)];
          cap = (g.span > 32'd1000) ? 32'd1004 : g.span + 32'd4;
          push_translate(g.src + $urandom_range(0, cap) - 32'd2);
        end
      end
    end
    total_ops = queued_ops.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for one result word per item, then watch for strays
    while (words_seen < total_ops) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && due_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
